### src/lrukv_pkg.sv
// Shared types and constants for the LRU key/value cache.
package lrukv_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_t;

  typedef struct packed {
    logic              fire;
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic [VAL_W-1:0]  value;
  } lookup_t;

endpackage

### src/lrukv_store.sv
// Entry store: parallel key match, recency ranks, replacement and update.
module lrukv_store #(
  parameter int MAX_ENTRIES = lrukv_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lrukv_pkg::CAP_W-1:0]   capacity,
  input  lrukv_pkg::cmd_t               cmd,
  output lrukv_pkg::lookup_t            lookup
);

  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (OW > lrukv_pkg::CAP_W) ? OW : lrukv_pkg::CAP_W;

  logic [lrukv_pkg::KEY_W-1:0] keys   [MAX_ENTRIES];
  logic [lrukv_pkg::VAL_W-1:0] values [MAX_ENTRIES];
  logic [RW-1:0]               rank   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]      valid;
  logic [OW-1:0]               occupancy;

  logic [MAX_ENTRIES-1:0]      hit_oh;
  logic [MAX_ENTRIES-1:0]      lru_oh;
  logic [MAX_ENTRIES-1:0]      free_oh;
  logic [MAX_ENTRIES-1:0]      slot_oh;
  logic [RW-1:0]               last_rank;
  logic [RW-1:0]               hit_rank;
  logic [lrukv_pkg::VAL_W-1:0] hit_value;
  logic [CW-1:0]               eff_cap;
  logic                        hit;
  logic                        full;
  logic                        touch;
  logic                        put_miss;

  always_comb begin
    last_rank = RW'(occupancy - OW'(1));
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_oh[i] = valid[i] && (keys[i] == cmd.key);
      lru_oh[i] = valid[i] && (rank[i] == last_rank);
      hit_rank  = hit_rank | (rank[i] & {RW{hit_oh[i]}});
      hit_value = hit_value | (values[i] & {lrukv_pkg::VAL_W{hit_oh[i]}});
    end
    free_oh = ~valid & (valid + MAX_ENTRIES'(1));
    hit     = |hit_oh;

    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(capacity) > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = CW'(capacity);
    end
    full     = CW'(occupancy) >= eff_cap;
    slot_oh  = full ? lru_oh : free_oh;
    touch    = cmd.fire && hit;
    put_miss = cmd.fire && (cmd.kind == lrukv_pkg::KIND_PUT) && !hit;

    lookup.hit   = hit;
    lookup.value = hit ? hit_value : lrukv_pkg::MISS_VALUE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (touch) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (hit_oh[i]) begin
          rank[i] <= '0;
        end else if (valid[i] && (rank[i] < hit_rank)) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
    end else if (put_miss) begin
      valid <= valid | slot_oh;
      if (!full) begin
        occupancy <= occupancy + OW'(1);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_oh[i]) begin
          rank[i] <= '0;
        end else if (valid[i]) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cmd.fire && (cmd.kind == lrukv_pkg::KIND_PUT)) begin
        if (hit ? hit_oh[i] : slot_oh[i]) begin
          values[i] <= cmd.value;
        end
        if (!hit && slot_oh[i]) begin
          keys[i] <= cmd.key;
        end
      end
    end
  end

endmodule

### src/lru_key_value_cache.sv
// Top level of the LRU key/value cache: stream handshakes, request and result registers.
//
//  channel   dir  signals                         beat carries
//  s_*       in   s_tvalid s_tready s_tdata s_tuser  get or put request
//  m_*       out  m_tvalid m_tready m_tdata m_tuser  get result (none for put)
//  cfg_*     in   cfg_valid cfg_ready cfg_data       capacity register
//
// One request per cycle while no get stalls: a beat waits in the request register
// while the store matches all entries in parallel and updates ranks, then a get
// result lands in the output register and m_tvalid rises.
// Reset empties both registers, clears all valid marks and sets capacity to 16.
// A get stalls in the request register while an untaken result holds m_tdata.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lrukv_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [lrukv_pkg::KEY_W+lrukv_pkg::VAL_W-1:0] s_tdata,  // key, value
  input  logic [0:0]                                s_tuser,  // kind
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [lrukv_pkg::VAL_W-1:0]               m_tdata,  // value_out
  output logic [0:0]                                m_tuser,  // hit
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [lrukv_pkg::CAP_W-1:0]               cfg_data
);

  logic                         in_valid;
  lrukv_pkg::kind_t             in_kind;
  logic [lrukv_pkg::KEY_W-1:0]  in_key;
  logic [lrukv_pkg::VAL_W-1:0]  in_value;
  logic                         out_valid;
  logic                         out_hit;
  logic [lrukv_pkg::VAL_W-1:0]  out_value;
  logic [lrukv_pkg::CAP_W-1:0]  capacity;
  logic                         advance;
  lrukv_pkg::cmd_t              cmd;
  lrukv_pkg::lookup_t           lookup;

  assign advance = in_valid &&
                   ((in_kind == lrukv_pkg::KIND_PUT) || !out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_value;
  assign m_tuser   = out_hit;

  assign cmd.fire  = advance;
  assign cmd.kind  = in_kind;
  assign cmd.key   = in_key;
  assign cmd.value = in_value;

  lrukv_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .cmd      (cmd),
    .lookup   (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrukv_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= lrukv_pkg::kind_t'(s_tuser[0]);
      in_key   <= s_tdata[lrukv_pkg::KEY_W-1:0];
      in_value <= s_tdata[lrukv_pkg::KEY_W+lrukv_pkg::VAL_W-1:lrukv_pkg::KEY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_kind == lrukv_pkg::KIND_GET)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_kind == lrukv_pkg::KIND_GET)) begin
      out_hit   <= lookup.hit;
      out_value <= lookup.value;
    end
  end

endmodule

### tb/lru_cache_checker.sv
// Checker for the LRU key/value cache: tracks the store, predicts get results, compares beats.
module lru_cache_checker
  import lrukv_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [KEY_W+VAL_W-1:0] s_tdata,   // key, value
  input  logic [0:0]             s_tuser,   // kind
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [VAL_W-1:0]       m_tdata,   // value_out
  input  logic [0:0]             m_tuser,   // hit
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data,
  output int                     pending,
  output int                     errors
);

  logic [KEY_W-1:0] slot_key  [MAX_ENTRIES];
  logic [VAL_W-1:0] slot_val  [MAX_ENTRIES];
  logic             slot_used [MAX_ENTRIES];
  logic [3:0]       slot_rank [MAX_ENTRIES];
  logic [CAP_W-1:0] occupancy;
  logic [CAP_W-1:0] capacity;
  lookup_t          lookup_q [$];
  int               err_count = 0;

  initial begin
    pending = 0;
    errors  = 0;
  end

  // Make slot e the most recent; slots more recent than it age by one.
  task automatic promote_slot(input int e);
    logic [3:0] r;
    r = slot_rank[e];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_used[i] && i != e && slot_rank[i] < r) slot_rank[i] = slot_rank[i] + 4'd1;
    end
    slot_rank[e] = '0;
  endtask

  task automatic apply_request(input kind_t kind, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
    int      found;
    int      slot;
    int      eff_cap;
    lookup_t res;
    found = -1;
    slot  = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
    end
    if (kind == KIND_GET) begin
      if (found >= 0) begin
        res.hit   = 1'b1;
        res.value = slot_val[found];
        promote_slot(found);
      end else begin
        res.hit   = 1'b0;
        res.value = MISS_VALUE;
      end
      lookup_q.push_back(res);
    end else if (found >= 0) begin
      slot_val[found] = value;
      promote_slot(found);
    end else begin
      eff_cap = (capacity == 0) ? 1 : (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
      if (occupancy >= eff_cap && occupancy > 0) begin
        // evict the least recent slot and reuse it
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_used[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
        end
        slot_used[slot] = 1'b0;
        occupancy = occupancy - 1'b1;
      end else begin
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
          if (!slot_used[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_used[i]) slot_rank[i] = slot_rank[i] + 4'd1;
        end
        slot_key[slot]  = key;
        slot_val[slot]  = value;
        slot_used[slot] = 1'b1;
        slot_rank[slot] = '0;
        occupancy = occupancy + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = '0;
      end
      occupancy = '0;
      capacity  = CAP_RESET;
      lookup_q.delete();
    end else begin
      // compare first: a result beat never belongs to a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (lookup_q.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected, got hit=%0b value=%h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = lookup_q.pop_front();
          if (m_tuser[0] !== want.hit) begin
            err_count++;
            $display("%0t: hit mismatch, expected %0b got %0b", $time, want.hit, m_tuser);
          end
          if (m_tdata !== want.value) begin
            err_count++;
            $display("%0t: value mismatch, expected %h got %h", $time, want.value, m_tdata);
          end
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (s_tvalid && s_tready)
        apply_request(kind_t'(s_tuser[0]), s_tdata[KEY_W-1:0], s_tdata[KEY_W +: VAL_W]);
    end
    pending <= lookup_q.size();
    errors  <= err_count;
  end

endmodule

### tb/tb_lru_key_value_cache.sv
// Testbench top for the LRU key/value cache: clock, reset, stimulus, flow control and verdict.
module tb_lru_key_value_cache;
  import lrukv_pkg::*;

  localparam int N_ENTRIES     = DEF_MAX_ENTRIES;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 130;
  localparam int N_PHASES      = 12;
  localparam int SETTLE_CYCLES = 4;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [KEY_W+VAL_W-1:0] s_tdata   = '0;   // key, value
  logic [0:0]             s_tuser   = '0;   // kind
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [VAL_W-1:0]       m_tdata;          // value_out
  logic [0:0]             m_tuser;          // hit
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data  = '0;

  int  pending;
  int  errors;
  int  cycle_count = 0;
  int  rdy_hold    = 0;
  bit  sink_stalls = 1'b1;
  bit  src_stalls  = 1'b0;

  logic [KEY_W-1:0] key_pool [0:31];
  logic [CAP_W-1:0] phase_caps [0:N_PHASES-1] =
    '{5'd31, 5'd16, 5'd3, 5'd1, 5'd0, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16, 5'd5, 5'd0};

  lru_key_value_cache #(.MAX_ENTRIES(N_ENTRIES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lru_cache_checker #(.MAX_ENTRIES(N_ENTRIES)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lru_key_value_cache NOT OK");
      $finish;
    end
  end

  // Result side: mostly short stalls, a few long ones, none while sink_stalls is clear once any hold runs out.
  always @(negedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else if (!sink_stalls) begin
      m_tready <= 1'b1;
    end else if (pick < 55) begin
      m_tready <= 1'b1;
      rdy_hold <= $urandom_range(0, 3);
    end else if (pick < 95) begin
      m_tready <= 1'b0;
      rdy_hold <= $urandom_range(0, 3);
    end else begin
      m_tready <= 1'b0;
      rdy_hold <= $urandom_range(10, 40);
    end
  end

  task automatic send_request(input kind_t kind, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {value, key};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_source();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap  = !src_stalls ? 0 : (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3)
                                                           : $urandom_range(8, 40);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // Hold the request side until every get result has been taken.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    // a trailing put gives no beat; let it clear the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    logic [KEY_W-1:0] key;
    kind_t            kind;
    int               eff_cap;
    int               n_keys;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty store, extreme keys and values, update in place
    send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_PUT, 32'h0000_0000, 32'h8000_0000);
    send_request(KIND_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_GET, 32'h1234_5678, 32'h0000_0000);

    // capacity lowered below occupancy: each new key swaps out one entry
    write_capacity(5'd1);
    send_request(KIND_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(KIND_GET, 32'hAAAA_AAAA, 32'h0000_0000);
    send_request(KIND_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(KIND_GET, 32'h0000_0000, 32'h0000_0000);

    // zero capacity acts as one
    write_capacity(5'd0);
    send_request(KIND_PUT, 32'h0000_0001, 32'h0000_0011);
    send_request(KIND_PUT, 32'h0000_0002, 32'h0000_0022);
    send_request(KIND_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0002, 32'h0000_0000);
    send_request(KIND_PUT, 32'h0000_0003, 32'h0000_0033);
    send_request(KIND_GET, 32'h0000_0002, 32'h0000_0000);

    // capacity above the table size clamps to the table size
    write_capacity(5'd31);
    for (int j = 0; j < 18; j++) send_request(KIND_PUT, 32'h0000_0100 + j, 32'hC000_0000 + j);
    send_request(KIND_GET, 32'h0000_0100, 32'h0000_0000);
    send_request(KIND_GET, 32'h0000_0102, 32'h0000_0000);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      cap = (ph == N_PHASES - 1) ? CAP_W'($urandom_range(0, 31)) : phase_caps[ph];
      write_capacity(cap);
      eff_cap = (cap == 0) ? 1 : (cap > N_ENTRIES) ? N_ENTRIES : int'(cap);
      n_keys  = eff_cap + 1 + $urandom_range(0, 4);
      for (int j = 0; j < n_keys; j++) key_pool[j] = $urandom;
      if ($urandom_range(0, 2) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 2) == 0) key_pool[n_keys-1] = '1;
      src_stalls  = (ph % 3) != 0;
      sink_stalls = (ph % 4) != 1;
      @(posedge clk);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        kind = ($urandom_range(0, 99) < 45) ? KIND_PUT : KIND_GET;
        key  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                           : key_pool[$urandom_range(0, n_keys - 1)];
        send_request(kind, key, $urandom);
        if ($urandom_range(0, 59) == 0) drain_results();
        else idle_source();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_lru_key_value_cache OK");
    end else begin
      $display("tb_lru_key_value_cache NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/lrukv_pkg.sv
src/lrukv_store.sv
src/lru_key_value_cache.sv
tb/lru_cache_checker.sv
tb/tb_lru_key_value_cache.sv
